/* sv/fbik_pkg.sv */
package fbik_pkg;

  localparam int ANGLE_FRAC_BITS   = 6;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int TAB_FRAC          = 24;
  localparam int ANGLE_SHIFT       = TAB_FRAC - ANGLE_FRAC_BITS;

  // square root: 30 result bits, radicand below 2^60
  localparam int SQ_STEPS = 30;
  localparam int SQ_W     = 2 * SQ_STEPS + 1;

  localparam int CW = 36;      // CORDIC x/y width
  localparam int ZW = 33;      // CORDIC angle accumulator width
  localparam int TW = ZW + 2;  // rounded angle width

  // config register indexes
  localparam logic [2:0] REG_LINK_ONE   = 3'd0;
  localparam logic [2:0] REG_LINK_TWO   = 3'd1;
  localparam logic [2:0] REG_LINK_THREE = 3'd2;
  localparam logic [2:0] REG_LINK_FOUR  = 3'd3;
  localparam logic [2:0] REG_BASE       = 3'd4;
  localparam logic [2:0] REG_SIDE       = 3'd5;

  // atan(2^-i) in degrees, 24 fraction bits
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717, 32'd15018523, 32'd7509720, 32'd3754918, 32'd1877466,
    32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
    32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229,
    32'd115, 32'd57, 32'd29, 32'd14, 32'd7, 32'd4, 32'd2, 32'd1, 32'd0
  };

  typedef logic signed [31:0]   coef_t;
  typedef logic signed [TW-1:0] theta_t;

  localparam logic signed [ZW-1:0] Z90 = ZW'(90) <<< TAB_FRAC;
  localparam theta_t ROUND_BIAS = TW'(1) <<< (ANGLE_SHIFT - 1);
  localparam theta_t DEG90      = TW'(90) <<< ANGLE_FRAC_BITS;
  localparam theta_t DEG270     = TW'(270) <<< ANGLE_FRAC_BITS;
  localparam theta_t DEG273     = TW'(273) <<< ANGLE_FRAC_BITS;
  localparam theta_t DEG_M90    = -DEG90;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
  } target_t;

  typedef struct packed {
    logic               servo_channel;
    logic signed [15:0] servo_angle;
    logic               used_fallback;
    logic               last_of_run;
  } result_t;

  typedef struct packed {
    coef_t a;
    coef_t b;
    coef_t c;
  } crank_coef_t;

  typedef struct packed {
    theta_t angle;
    logic   fallback;
  } crank_res_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 ok;
  } cordic_t;

  // divide by 32, truncating toward zero
  function automatic coef_t trunc_div32(input logic signed [39:0] v);
    logic signed [39:0] t;
    t = v + (v[39] ? 40'sd31 : 40'sd0);
    return coef_t'(t >>> 5);
  endfunction

  // q is already nonnegative; q == 0 gives +/-90 or an invalid root
  function automatic cordic_t cordic_init(input logic signed [33:0] p,
                                          input logic signed [33:0] q);
    cordic_t r;
    r.x  = CW'(q);
    r.y  = CW'(p);
    r.z  = '0;
    r.ok = 1'b1;
    if (q == 34'sd0) begin
      r.x  = '0;
      r.y  = '0;
      r.ok = (p != 34'sd0);
      if (p > 34'sd0) begin
        r.z = Z90;
      end else if (p < 34'sd0) begin
        r.z = -Z90;
      end
    end
    return r;
  endfunction

  function automatic cordic_t cordic_step(input cordic_t c, input logic [4:0] i);
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    cordic_t r;
    r  = c;
    dx = c.y >>> i;
    dy = c.x >>> i;
    if (c.y > 0) begin
      r.x = c.x + dx;
      r.y = c.y - dy;
      r.z = c.z + ZW'(ATAN_TAB[i]);
    end else if (c.y < 0) begin
      r.x = c.x - dx;
      r.y = c.y + dy;
      r.z = c.z - ZW'(ATAN_TAB[i]);
    end
    return r;
  endfunction

endpackage

/* sv/fbik_front.sv */
module fbik_front import fbik_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_vld,
  input  target_t     tgt,
  input  logic [15:0] l1,
  input  logic [15:0] l2,
  input  logic [15:0] l3,
  input  logic [15:0] l4,
  input  logic [15:0] l5,
  output logic        vld,
  output crank_coef_t alpha_coef,
  output crank_coef_t beta_coef
);

  logic               vld1;
  logic signed [32:0] xl1, yl1, yl4;
  logic signed [34:0] xrl4;
  logic [31:0]        xx, yy, l1sq, l2sq, l3sq, l4sq;
  logic [33:0]        xrxr;
  logic signed [17:0] xr;
  logic signed [35:0] xr_sq;
  logic signed [39:0] c_sum, f_sum;

  assign xr    = 18'(tgt.target_x) - 18'($signed({1'b0, l5}));
  assign xr_sq = 36'(xr) * 36'(xr);

  // stage 1: products
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld  <= 1'b0;
    end else if (en) begin
      vld1 <= in_vld;
      vld  <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xl1  <= 33'(tgt.target_x) * 33'($signed({1'b0, l1}));
      yl1  <= 33'(tgt.target_y) * 33'($signed({1'b0, l1}));
      yl4  <= 33'(tgt.target_y) * 33'($signed({1'b0, l4}));
      xrl4 <= 35'(xr) * 35'($signed({1'b0, l4}));
      xx   <= 32'(tgt.target_x) * 32'(tgt.target_x);
      yy   <= 32'(tgt.target_y) * 32'(tgt.target_y);
      l1sq <= 32'(l1) * 32'(l1);
      l2sq <= 32'(l2) * 32'(l2);
      l3sq <= 32'(l3) * 32'(l3);
      l4sq <= 32'(l4) * 32'(l4);
      xrxr <= xr_sq[33:0];
    end
  end

  // stage 2: sums, scaled down by 32
  assign c_sum = 40'(xx) + 40'(yy) + 40'(l1sq) - 40'(l2sq);
  assign f_sum = 40'(xrxr) + 40'(l4sq) + 40'(yy) - 40'(l3sq);

  always_ff @(posedge clk) begin
    if (en) begin
      alpha_coef.a <= trunc_div32(40'(xl1) <<< 1);
      alpha_coef.b <= trunc_div32(40'(yl1) <<< 1);
      alpha_coef.c <= trunc_div32(c_sum);
      beta_coef.a  <= trunc_div32(40'(xrl4) <<< 1);
      beta_coef.b  <= trunc_div32(40'(yl4) <<< 1);
      beta_coef.c  <= trunc_div32(f_sum);
    end
  end

endmodule

/* sv/fbik_crank.sv */
module fbik_crank import fbik_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_vld,
  input  crank_coef_t coef,
  input  logic        wide_range,
  output logic        vld,
  output crank_res_t  res
);

  localparam int NI = CORDIC_ITERATIONS;

  // squares
  logic               vld_c1;
  logic signed [63:0] sa, sb, sc;
  coef_t              b_c1;
  logic signed [32:0] q_c1;
  logic signed [63:0] disc;

  // square root pipe
  logic [SQ_W-1:0]    sv   [SQ_STEPS+1];
  logic [SQ_W-1:0]    sr   [SQ_STEPS+1];
  coef_t              pb   [SQ_STEPS+1];
  logic signed [32:0] pq   [SQ_STEPS+1];
  logic               pneg [SQ_STEPS+1];
  logic               pvld [SQ_STEPS+1];

  // CORDIC pipe, one lane per root
  cordic_t            cs   [2][NI+1];
  logic               cneg [NI+1];
  logic               cvld [NI+1];

  logic signed [33:0] s_ext, p_plus, p_minus, q_ext;
  theta_t             t0, t1, hi_lim;
  logic               in0, in1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_c1  <= 1'b0;
      pvld[0] <= 1'b0;
    end else if (en) begin
      vld_c1  <= in_vld;
      pvld[0] <= vld_c1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa   <= 64'(coef.a) * 64'(coef.a);
      sb   <= 64'(coef.b) * 64'(coef.b);
      sc   <= 64'(coef.c) * 64'(coef.c);
      b_c1 <= coef.b;
      q_c1 <= 33'(coef.a) + 33'(coef.c);
    end
  end

  assign disc = sa + sb - sc;

  always_ff @(posedge clk) begin
    if (en) begin
      sv[0]   <= disc[SQ_W-1:0];
      sr[0]   <= '0;
      pb[0]   <= b_c1;
      pq[0]   <= q_c1;
      pneg[0] <= disc[63];
    end
  end

  // one root bit per stage
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - j));
    logic [SQ_W-1:0] trial;
    assign trial = sr[j] + SQ_BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        pvld[j+1] <= 1'b0;
      end else if (en) begin
        pvld[j+1] <= pvld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (sv[j] >= trial) begin
          sv[j+1] <= sv[j] - trial;
          sr[j+1] <= (sr[j] >> 1) + SQ_BIT;
        end else begin
          sv[j+1] <= sv[j];
          sr[j+1] <= sr[j] >> 1;
        end
        pb[j+1]   <= pb[j];
        pq[j+1]   <= pq[j];
        pneg[j+1] <= pneg[j];
      end
    end
  end

  // numerators b +/- s; flip signs for a negative denominator
  assign s_ext   = 34'($signed({1'b0, sr[SQ_STEPS][SQ_STEPS:0]}));
  assign q_ext   = 34'(pq[SQ_STEPS]);
  assign p_plus  = 34'(pb[SQ_STEPS]) + s_ext;
  assign p_minus = 34'(pb[SQ_STEPS]) - s_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      cvld[0] <= 1'b0;
    end else if (en) begin
      cvld[0] <= pvld[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (q_ext < 0) begin
        cs[0][0] <= cordic_init(-p_plus, -q_ext);
        cs[1][0] <= cordic_init(-p_minus, -q_ext);
      end else begin
        cs[0][0] <= cordic_init(p_plus, q_ext);
        cs[1][0] <= cordic_init(p_minus, q_ext);
      end
      cneg[0] <= pneg[SQ_STEPS];
    end
  end

  for (genvar i = 0; i < NI; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        cvld[i+1] <= 1'b0;
      end else if (en) begin
        cvld[i+1] <= cvld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cs[0][i+1] <= cordic_step(cs[0][i], 5'(i));
        cs[1][i+1] <= cordic_step(cs[1][i], 5'(i));
        cneg[i+1]  <= cneg[i];
      end
    end
  end

  // theta = 2*atan, rounded half up; first root in range wins
  assign t0     = ((TW'(cs[0][NI].z) <<< 1) + ROUND_BIAS) >>> ANGLE_SHIFT;
  assign t1     = ((TW'(cs[1][NI].z) <<< 1) + ROUND_BIAS) >>> ANGLE_SHIFT;
  assign hi_lim = wide_range ? DEG270 : DEG90;
  assign in0    = !cneg[NI] && cs[0][NI].ok && (t0 >= DEG_M90) && (t0 <= hi_lim);
  assign in1    = !cneg[NI] && cs[1][NI].ok && (t1 >= DEG_M90) && (t1 <= hi_lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= cvld[NI];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (in0) begin
        res.angle    <= t0;
        res.fallback <= 1'b0;
      end else if (in1) begin
        res.angle    <= t1;
        res.fallback <= 1'b0;
      end else begin
        res.angle    <= DEG90;
        res.fallback <= 1'b1;
      end
    end
  end

endmodule

/* sv/fbik_out.sv */
module fbik_out import fbik_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_vld,
  input  crank_res_t alpha,
  input  crank_res_t beta,
  input  logic       leg_side,
  output logic       en,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result
);

  logic    has_item;
  logic    phase;
  logic    side_r;
  result_t w0, w1;
  theta_t  am;

  always_comb begin
    if (leg_side) begin
      am = (alpha.angle < 0) ? -alpha.angle : alpha.angle;
    end else begin
      am = (alpha.angle < 0) ? (-alpha.angle - DEG90) : (DEG273 - alpha.angle);
    end
  end

  assign en = !has_item || (!result_stall && (phase || !side_r));

  always_ff @(posedge clk) begin
    if (rst) begin
      has_item <= 1'b0;
      phase    <= 1'b0;
      side_r   <= 1'b1;
    end else if (en) begin
      has_item <= in_vld;
      phase    <= 1'b0;
      side_r   <= leg_side;
    end else if (has_item && !result_stall) begin
      phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w0.servo_channel <= 1'b0;
      w0.servo_angle   <= am[15:0];
      w0.used_fallback <= alpha.fallback;
      w0.last_of_run   <= !leg_side;
      w1.servo_channel <= 1'b1;
      w1.servo_angle   <= beta.angle[15:0];
      w1.used_fallback <= beta.fallback;
      w1.last_of_run   <= 1'b1;
    end
  end

  assign result_valid = has_item;
  assign result       = phase ? w1 : w0;

endmodule

/* sv/five_bar_leg_inverse_kinematics_unit.sv */
// Five-bar leg inverse kinematics: a target foot position (Q8 mm) goes in as one word and the
// crank angles (1/64 degree) come out as result words. Right leg (leg_side = 1) gives |alpha| on
// channel 0 then beta on channel 1; left leg gives one mapped alpha word on channel 0. An angle
// whose two half-angle roots both fall out of range is set to 90 degrees ahead of the left-leg
// alpha mapping, with used_fallback set. Both cranks are solved side by side in a 53-stage
// pipeline: two stages form the coefficients, then per crank squares, discriminant, a 30-stage
// square root (one root bit per stage), root setup, 16 CORDIC stages and angle selection, then
// the shared output register, from which a word leaves once it is not stalled. A new target
// word is taken every cycle in left-leg mode while the output is not stalled; in right-leg mode
// the next one waits until both words of the last one have left on the single result channel.
// The whole pipe holds while the output word is stalled. cfg_ready is always high; write
// registers only while idle.
module five_bar_leg_inverse_kinematics_unit import fbik_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        target_valid,
  output logic        target_stall,
  input  target_t     target,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] link_one, link_two, link_three, link_four, base_offset;
  logic        leg_side;

  logic        en;
  logic        front_vld, a_vld, b_vld;
  crank_coef_t alpha_coef, beta_coef;
  crank_res_t  alpha_res, beta_res;

  assign cfg_ready    = 1'b1;
  assign target_stall = !en;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      link_one    <= '0;
      link_two    <= '0;
      link_three  <= '0;
      link_four   <= '0;
      base_offset <= '0;
      leg_side    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LINK_ONE:   link_one    <= cfg_data;
        REG_LINK_TWO:   link_two    <= cfg_data;
        REG_LINK_THREE: link_three  <= cfg_data;
        REG_LINK_FOUR:  link_four   <= cfg_data;
        REG_BASE:       base_offset <= cfg_data;
        REG_SIDE:       leg_side    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  fbik_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_vld     (target_valid),
    .tgt        (target),
    .l1         (link_one),
    .l2         (link_two),
    .l3         (link_three),
    .l4         (link_four),
    .l5         (base_offset),
    .vld        (front_vld),
    .alpha_coef (alpha_coef),
    .beta_coef  (beta_coef)
  );

  // alpha: -90..270 deg
  fbik_crank u_alpha (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_vld     (front_vld),
    .coef       (alpha_coef),
    .wide_range (1'b1),
    .vld        (a_vld),
    .res        (alpha_res)
  );

  // beta: -90..90 deg
  fbik_crank u_beta (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_vld     (front_vld),
    .coef       (beta_coef),
    .wide_range (1'b0),
    .vld        (b_vld),
    .res        (beta_res)
  );

  fbik_out u_out (
    .clk          (clk),
    .rst          (rst),
    .in_vld       (a_vld && b_vld),
    .alpha        (alpha_res),
    .beta         (beta_res),
    .leg_side     (leg_side),
    .en           (en),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // both crank lanes stay in lockstep
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst) a_vld == b_vld)
    else $error("crank lanes out of step");

  // beta word always closes the run
  a_ch1_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.servo_channel |-> result.last_of_run)
    else $error("channel 1 word not last");

  // a taken non-final word is followed by the beta word
  a_beta_follows: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !result.last_of_run
    |=> result_valid && result.servo_channel)
    else $error("beta word missing");

  // empty output register never holds off the input
  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !target_stall)
    else $error("stall with empty output");

endmodule
